@@ rtl/piaw_pkg.sv @@
// piaw_pkg: shared types and constants of the two-channel pi controller
// no dependencies; used by pi_controller_antiwindup and tb_top

package piaw_pkg;

   localparam int CHANNELS = 2;
   localparam int CH_W     = 1;

   localparam int ERR_W = 13;
   localparam int PT_W  = 29;
   localparam int ACC_W = 48;
   localparam int P2K_W = 41;
   localparam int NUM_W = 50;

   localparam int PULSE_MAX = 255;

   localparam logic signed [11:0] TEMP_FAULT    = 12'sd850;
   localparam logic [9:0]         ADC_FAULT_MIN = 10'd80;

   localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // drive = floor(num / 10000), exact for num below 2^29
   localparam int          DIV_SHIFT = 43;
   localparam logic [29:0] DIV_RECIP = 30'd879609303;
   localparam logic [NUM_W-1:0] NUM_SAT = 50'd327680000;
   localparam logic [14:0] DRIVE_MAX = 15'h7fff;

   typedef enum logic [2:0] {
      CSR_SETPOINT_CH0  = 3'd0,
      CSR_SETPOINT_CH1  = 3'd1,
      CSR_SETPOINT_HUM  = 3'd2,
      CSR_GAIN_P        = 3'd3,
      CSR_GAIN_I        = 3'd4,
      CSR_PULSE_MODE    = 3'd5,
      CSR_PULSE_PERIOD  = 3'd6,
      CSR_HUMIDITY_SENS = 3'd7
   } csr_idx_type;

endpackage

@@ rtl/piaw_ram.sv @@
// piaw_ram: generic single-write, single-read ram with registered read data
// no dependencies

module piaw_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/pi_controller_antiwindup.sv @@
// pi_controller_antiwindup: two-channel pi controller, integrator reset anti-windup
// depends on piaw_pkg and piaw_ram (integrator store)
// rsp_valid is registered via s1 to s4 and out; one word per cycle unless stalled
// integrators sit in a 2-entry ram read in stage 1 and written in stage 2, forwarded
// reset (synchronous): pipeline empty, csr registers zero, integrators read as zero

module pi_controller_antiwindup #(
   parameter int unsigned FULL_DRIVE = 255
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_channel,
   input  logic signed [11:0]  req_measured_temp,
   input  logic [9:0]          req_measured_humidity,
   input  logic [9:0]          req_humidity_adc,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [14:0]         rsp_drive,
   output logic signed [12:0]  rsp_control_error,
   output logic                rsp_sensor_fault,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_wdata
);

   localparam int PULSE_LIM = (piaw_pkg::PULSE_MAX * FULL_DRIVE) / 2;
   localparam int FULL_LIM  = 2 * FULL_DRIVE;
   localparam int LIM_MAX   = (PULSE_LIM > FULL_LIM) ? PULSE_LIM : FULL_LIM;
   localparam int LIM_W     = $clog2(LIM_MAX + 1);
   localparam int LIM5_W    = LIM_W + 3;
   localparam int CMP_W     = ((LIM5_W + 1 > piaw_pkg::PT_W) ? LIM5_W + 1 : piaw_pkg::PT_W) + 1;
   localparam logic [LIM_W:0]   FD_V     = FULL_DRIVE[LIM_W:0];
   localparam logic [LIM_W-1:0] LIM_FULL = FULL_LIM[LIM_W-1:0];

   localparam int ERR_W = piaw_pkg::ERR_W;
   localparam int PT_W  = piaw_pkg::PT_W;
   localparam int ACC_W = piaw_pkg::ACC_W;
   localparam int P2K_W = piaw_pkg::P2K_W;
   localparam int NUM_W = piaw_pkg::NUM_W;

   // configuration registers
   logic signed [11:0] sp0_ff, sp1_ff;
   logic [9:0]         sph_ff;
   logic [15:0]        kp_ff, ki_ff;
   logic               pmode_ff, hum_ff;
   logic [7:0]         pulse_ff;

   // pipeline
   logic en;
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, out_vld_ff;

   logic                    s1_ch_ff, s2_ch_ff;
   logic signed [ERR_W-1:0] s1_err_ff, s2_err_ff, s3_err_ff, s4_err_ff, out_err_ff;
   logic                    s1_flt_ff, s2_flt_ff, s3_flt_ff, s4_flt_ff, out_flt_ff;
   logic [LIM_W-1:0]        s1_lim_ff;
   logic [LIM5_W-1:0]       s2_lim5_ff;
   logic [PT_W-1:0]         s2_pt_ff, s2_ip_ff;
   logic [ACC_W-1:0]        s3_acc_ff;
   logic [P2K_W-1:0]        s3_p2k_ff;
   logic [PT_W-1:0]         s4_num_ff;
   logic                    s4_zero_ff, s4_sat_ff;
   logic [14:0]             out_drive_ff;

   // integrator store, entry valid bits and write forwarding
   logic [piaw_pkg::CHANNELS-1:0] ent_vld_ff;
   logic                          rd_vld_ff;
   logic                          fwd_vld_ff;
   logic                          fwd_ch_ff;
   logic [ACC_W-1:0]              fwd_data_ff;
   logic [ACC_W-1:0]              ram_rd;
   logic                          wr_en;

   // stage 0 signals
   logic                    s1_flt_in;
   logic signed [ERR_W-1:0] s1_err_in, err_hum, err_tmp;
   logic signed [11:0]      sp_sel;
   logic [LIM_W:0]          pprod;
   logic [LIM_W-1:0]        s1_lim_in;

   // stage 1 signals
   logic signed [29:0] err_x, kp_x, ki_x, pmul, imul;
   logic [LIM5_W-1:0]  s2_lim5_in;

   // stage 2 signals
   logic [ACC_W-1:0]      integ;
   logic [ACC_W:0]        isum;
   logic [ACC_W-1:0]      isat;
   logic signed [CMP_W-1:0] pt_c, lim_c;
   logic                  clr;
   logic [ACC_W-1:0]      s3_acc_in;
   logic signed [P2K_W-1:0] pt_x, s3_p2k_in;

   // stage 3 signals
   logic signed [NUM_W-1:0] num;
   logic                    s4_zero_in, s4_sat_in;

   // stage 4 signals
   logic [58:0] qprod;
   logic [14:0] out_drive_in;

   assign en        = !(out_vld_ff && rsp_stall);
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sp0_ff   <= '0;
         sp1_ff   <= '0;
         sph_ff   <= '0;
         kp_ff    <= '0;
         ki_ff    <= '0;
         pmode_ff <= 1'b0;
         pulse_ff <= '0;
         hum_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (piaw_pkg::csr_idx_type'(csr_index))
            piaw_pkg::CSR_SETPOINT_CH0:  sp0_ff   <= csr_wdata[11:0];
            piaw_pkg::CSR_SETPOINT_CH1:  sp1_ff   <= csr_wdata[11:0];
            piaw_pkg::CSR_SETPOINT_HUM:  sph_ff   <= csr_wdata[9:0];
            piaw_pkg::CSR_GAIN_P:        kp_ff    <= csr_wdata;
            piaw_pkg::CSR_GAIN_I:        ki_ff    <= csr_wdata;
            piaw_pkg::CSR_PULSE_MODE:    pmode_ff <= csr_wdata[0];
            piaw_pkg::CSR_PULSE_PERIOD:  pulse_ff <= csr_wdata[7:0];
            piaw_pkg::CSR_HUMIDITY_SENS: hum_ff   <= csr_wdata[0];
         endcase
      end
   end

   // stage 0: error, fault check, limit
   always_comb begin
      err_hum = $signed({3'b000, sph_ff}) - $signed({3'b000, req_measured_humidity});
      sp_sel  = req_channel ? sp1_ff : sp0_ff;
      err_tmp = {sp_sel[11], sp_sel} - {req_measured_temp[11], req_measured_temp};
      if (req_channel && hum_ff) begin
         s1_flt_in = (req_humidity_adc < piaw_pkg::ADC_FAULT_MIN);
         s1_err_in = s1_flt_in ? '0 : err_hum;
      end else begin
         s1_flt_in = (req_measured_temp >= piaw_pkg::TEMP_FAULT);
         s1_err_in = s1_flt_in ? '0 : err_tmp;
      end
      pprod     = {{(LIM_W - 7){1'b0}}, pulse_ff} * FD_V;
      s1_lim_in = (req_channel && pmode_ff) ? pprod[LIM_W:1] : LIM_FULL;
   end

   // stage 1: products, limit times five
   always_comb begin
      err_x      = {{(30 - ERR_W){s1_err_ff[ERR_W-1]}}, s1_err_ff};
      kp_x       = {14'b0, kp_ff};
      ki_x       = {14'b0, ki_ff};
      pmul       = err_x * kp_x;
      imul       = err_x * ki_x;
      s2_lim5_in = {3'b000, s1_lim_ff} + {1'b0, s1_lim_ff, 2'b00};
   end

   // stage 2: integrator update, saturation, clear
   always_comb begin
      if (fwd_vld_ff && (fwd_ch_ff == s2_ch_ff)) begin
         integ = fwd_data_ff;
      end else if (rd_vld_ff) begin
         integ = ram_rd;
      end else begin
         integ = '0;
      end
      isum = {integ[ACC_W-1], integ} + {{(ACC_W + 1 - PT_W){s2_ip_ff[PT_W-1]}}, s2_ip_ff};
      priority if (isum[ACC_W:ACC_W-1] == 2'b01) begin
         isat = piaw_pkg::ACC_MAX;
      end else if (isum[ACC_W:ACC_W-1] == 2'b10) begin
         isat = piaw_pkg::ACC_MIN;
      end else begin
         isat = isum[ACC_W-1:0];
      end
      pt_c  = {{(CMP_W - PT_W){s2_pt_ff[PT_W-1]}}, s2_pt_ff};
      lim_c = {{(CMP_W - LIM5_W){1'b0}}, s2_lim5_ff};
      clr   = (pt_c >= lim_c) || (pt_c <= -lim_c);
      s3_acc_in = clr ? '0 : isat;
      pt_x      = {{(P2K_W - PT_W){s2_pt_ff[PT_W-1]}}, s2_pt_ff};
      s3_p2k_in = (pt_x <<< 11) - (pt_x <<< 5) - (pt_x <<< 4);
   end

   assign wr_en = en && s2_vld_ff;

   piaw_ram #(
      .WIDTH(ACC_W),
      .DEPTH(piaw_pkg::CHANNELS)
   ) u_integ_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s2_ch_ff),
      .wr_data (s3_acc_in),
      .rd_en   (en),
      .rd_addr (s1_ch_ff),
      .rd_data (ram_rd)
   );

   // stage 3: numerator, range checks
   always_comb begin
      num = $signed({{(NUM_W - ACC_W){s3_acc_ff[ACC_W-1]}}, s3_acc_ff})
          + $signed({{(NUM_W - P2K_W){s3_p2k_ff[P2K_W-1]}}, s3_p2k_ff});
      s4_zero_in = num[NUM_W-1] || (num == '0);
      s4_sat_in  = !num[NUM_W-1] && (num >= $signed(piaw_pkg::NUM_SAT));
   end

   // stage 4: divide by 10000 through the reciprocal
   always_comb begin
      qprod = {30'b0, s4_num_ff} * {29'b0, piaw_pkg::DIV_RECIP};
      priority if (s4_sat_ff) begin
         out_drive_in = piaw_pkg::DRIVE_MAX;
      end else if (s4_zero_ff) begin
         out_drive_in = '0;
      end else begin
         out_drive_in = qprod[piaw_pkg::DIV_SHIFT+14:piaw_pkg::DIV_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         ent_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
         fwd_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff  <= req_valid;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff;
         out_vld_ff <= s4_vld_ff;
         rd_vld_ff  <= ent_vld_ff[s1_ch_ff];
         if (s2_vld_ff) begin
            ent_vld_ff[s2_ch_ff] <= 1'b1;
            fwd_vld_ff           <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ch_ff     <= req_channel;
         s1_err_ff    <= s1_err_in;
         s1_flt_ff    <= s1_flt_in;
         s1_lim_ff    <= s1_lim_in;
         s2_ch_ff     <= s1_ch_ff;
         s2_err_ff    <= s1_err_ff;
         s2_flt_ff    <= s1_flt_ff;
         s2_lim5_ff   <= s2_lim5_in;
         s2_pt_ff     <= pmul[PT_W-1:0];
         s2_ip_ff     <= imul[PT_W-1:0];
         s3_err_ff    <= s2_err_ff;
         s3_flt_ff    <= s2_flt_ff;
         s3_acc_ff    <= s3_acc_in;
         s3_p2k_ff    <= s3_p2k_in;
         s4_err_ff    <= s3_err_ff;
         s4_flt_ff    <= s3_flt_ff;
         s4_num_ff    <= num[PT_W-1:0];
         s4_zero_ff   <= s4_zero_in;
         s4_sat_ff    <= s4_sat_in;
         out_err_ff   <= s4_err_ff;
         out_flt_ff   <= s4_flt_ff;
         out_drive_ff <= out_drive_in;
         if (s2_vld_ff) begin
            fwd_ch_ff   <= s2_ch_ff;
            fwd_data_ff <= s3_acc_in;
         end
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_drive         = out_drive_ff;
   assign rsp_control_error = out_err_ff;
   assign rsp_sensor_fault  = out_flt_ff;

   // checks
   a_clear_writes_zero: assert property (@(posedge clock) disable iff (reset)
      (wr_en && clr) |=> (fwd_data_ff == '0))
      else $error("integrator clear did not write zero");

   a_fault_zero_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sensor_fault) |-> (rsp_control_error == '0))
      else $error("fault word carries nonzero error");

   a_entry_valid_after_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (ent_vld_ff[$past(s2_ch_ff)] && fwd_vld_ff))
      else $error("integrator entry not marked after write");

endmodule

@@ verif/tb_top.sv @@
// tb_top: self-checking testbench of pi_controller_antiwindup, random idling on both channels
// depends on piaw_pkg and pi_controller_antiwindup rtl; typed rows or a built-in predictor
// check every result word of a directed table, an integrator build-up run and random phases
`timescale 1ns / 100ps

module tb_top;

   localparam int     DRIVE_FULL = 255;
   localparam longint INTEG_MAX  = (longint'(1) <<< 47) - 1;
   localparam longint INTEG_MIN  = -INTEG_MAX - 1;
   localparam int     SOAK_WORDS = 24;
   localparam int     PHASES     = 8;
   localparam int     PHASE_WORDS = 240;

   typedef struct packed {
      logic [14:0] drive;
      logic [12:0] err;
      logic        fault;
   } result_type;

   typedef struct {
      bit                    is_csr;
      piaw_pkg::csr_idx_type idx;
      logic [15:0]           wdata;
      bit                    ch;
      logic signed [11:0]    temp;
      logic [9:0]            hum;
      logic [9:0]            adc;
      bit                    typed;
      result_type            res;
   } stim_row_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_channel = 1'b0;
   logic signed [11:0] req_measured_temp = '0;
   logic [9:0]         req_measured_humidity = '0;
   logic [9:0]         req_humidity_adc = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [14:0]        rsp_drive;
   logic signed [12:0] rsp_control_error;
   logic               rsp_sensor_fault;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [15:0]        csr_wdata = '0;

   pi_controller_antiwindup #(.FULL_DRIVE(DRIVE_FULL)) dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_channel           (req_channel),
      .req_measured_temp     (req_measured_temp),
      .req_measured_humidity (req_measured_humidity),
      .req_humidity_adc      (req_humidity_adc),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_drive             (rsp_drive),
      .rsp_control_error     (rsp_control_error),
      .rsp_sensor_fault      (rsp_sensor_fault),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   // predictor copy of the registers and integrators
   logic signed [11:0] cfg_sp0 = '0;
   logic signed [11:0] cfg_sp1 = '0;
   logic [9:0]         cfg_sph = '0;
   logic [15:0]        cfg_kp = '0;
   logic [15:0]        cfg_ki = '0;
   logic               cfg_pmode = 1'b0;
   logic [7:0]         cfg_pperiod = '0;
   logic               cfg_hum = 1'b0;
   longint             integ_sum [piaw_pkg::CHANNELS] = '{default: 0};

   result_type   pending_results [$];
   stim_row_type stim_table [$];
   int           mismatch_count = 0;
   int           idle_pct = 30;
   int           stall_left = 0;
   bit           cur_ch = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAIL pi_controller_antiwindup");
      $finish;
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 99) >= idle_pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic void apply_csr(piaw_pkg::csr_idx_type idx, logic [15:0] d);
      case (idx)
         piaw_pkg::CSR_SETPOINT_CH0:  cfg_sp0 = d[11:0];
         piaw_pkg::CSR_SETPOINT_CH1:  cfg_sp1 = d[11:0];
         piaw_pkg::CSR_SETPOINT_HUM:  cfg_sph = d[9:0];
         piaw_pkg::CSR_GAIN_P:        cfg_kp = d;
         piaw_pkg::CSR_GAIN_I:        cfg_ki = d;
         piaw_pkg::CSR_PULSE_MODE:    cfg_pmode = d[0];
         piaw_pkg::CSR_PULSE_PERIOD:  cfg_pperiod = d[7:0];
         piaw_pkg::CSR_HUMIDITY_SENS: cfg_hum = d[0];
         default: ;
      endcase
   endfunction

   function automatic result_type predict_drive(bit ch, logic signed [11:0] temp,
                                                logic [9:0] hum, logic [9:0] adc);
      longint     err, lim, pterm, acc, num, drv;
      result_type r;
      r.fault = 1'b0;
      err = 0;
      if (ch && cfg_hum) begin
         if (adc < piaw_pkg::ADC_FAULT_MIN) r.fault = 1'b1;
         else err = longint'(cfg_sph) - longint'(hum);
      end else begin
         if (temp >= piaw_pkg::TEMP_FAULT) r.fault = 1'b1;
         else err = (ch ? longint'(cfg_sp1) : longint'(cfg_sp0)) - longint'(temp);
      end
      lim = (ch && cfg_pmode) ? longint'(cfg_pperiod) * DRIVE_FULL / 2
                              : longint'(2 * DRIVE_FULL);
      pterm = err * longint'(cfg_kp);
      acc = integ_sum[ch] + err * longint'(cfg_ki);
      if (acc > INTEG_MAX) acc = INTEG_MAX;
      if (acc < INTEG_MIN) acc = INTEG_MIN;
      // anti-windup: proportional part at the limit clears the integrator
      if (pterm >= 5 * lim || pterm <= -5 * lim) acc = 0;
      integ_sum[ch] = acc;
      num = pterm * 2000 + acc;
      drv = (num <= 0) ? 0 : num / 10000;
      if (drv > 32767) drv = 32767;
      r.drive = drv[14:0];
      r.err = err[12:0];
      return r;
   endfunction

   function automatic stim_row_type item_row(bit ch, int temp, int hum, int adc,
                                             bit typed = 0, int drv = 0, int err = 0,
                                             bit flt = 0);
      stim_row_type s;
      s.is_csr = 0;
      s.idx = piaw_pkg::CSR_SETPOINT_CH0;
      s.wdata = '0;
      s.ch = ch;
      s.temp = temp[11:0];
      s.hum = hum[9:0];
      s.adc = adc[9:0];
      s.typed = typed;
      s.res.drive = drv[14:0];
      s.res.err = err[12:0];
      s.res.fault = flt;
      return s;
   endfunction

   function automatic stim_row_type csr_row(piaw_pkg::csr_idx_type idx, logic [15:0] d);
      stim_row_type s;
      s = item_row(0, 0, 0, 0);
      s.is_csr = 1;
      s.idx = idx;
      s.wdata = d;
      return s;
   endfunction

   task automatic note_failure(bit have_want, result_type want, result_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         if (have_want) begin
            $display("mismatch at %0t: expected drive %0d error %0d fault %0d,",
                     $time, want.drive, $signed(want.err), want.fault);
            $display("   actual drive %0d error %0d fault %0d",
                     got.drive, $signed(got.err), got.fault);
         end else begin
            $display("unexpected word at %0t: drive %0d error %0d fault %0d",
                     $time, got.drive, $signed(got.err), got.fault);
         end
      end
   endtask

   always @(posedge clock) begin
      int g;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         stall_left--;
      end else begin
         g = pick_gap();
         rsp_stall <= (g != 0);
         stall_left = (g == 0) ? 0 : g - 1;
      end
   end

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_drive, rsp_control_error, rsp_sensor_fault};
         if (pending_results.size() == 0) begin
            note_failure(0, got, got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) note_failure(1, want, got);
         end
      end
   end

   task automatic send_word(bit ch, logic signed [11:0] temp, logic [9:0] hum,
                            logic [9:0] adc, output result_type r);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_channel <= ch;
      req_measured_temp <= temp;
      req_measured_humidity <= hum;
      req_humidity_adc <= adc;
      do @(posedge clock); while (req_stall);
      r = predict_drive(ch, temp, hum, adc);
   endtask

   task automatic csr_write(piaw_pkg::csr_idx_type idx, logic [15:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, d);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic program_phase(int p);
      logic [11:0] sp0, sp1;
      logic [15:0] sph, kp, ki, pmode, pper, hmode;
      if (p == 0) begin
         sp0 = 12'h800; sp1 = 12'h800; sph = 0; kp = 0; ki = 0;
         pmode = 0; pper = 0; hmode = 0;
      end else if (p == 1) begin
         sp0 = 12'h7ff; sp1 = 12'h7ff; sph = 1000; kp = 16'hffff; ki = 16'hffff;
         pmode = 1; pper = 255; hmode = 1;
      end else begin
         sp0 = 12'($urandom_range(0, 4095));
         sp1 = 12'($urandom_range(0, 4095));
         sph = 16'($urandom_range(0, 1000));
         case ($urandom_range(0, 3))
            0: kp = 16'($urandom_range(0, 3));
            1: kp = 16'($urandom_range(1, 40));
            2: kp = 16'($urandom_range(0, 65535));
            default: kp = 16'hffff;
         endcase
         case ($urandom_range(0, 3))
            0: ki = 16'($urandom_range(0, 20));
            1: ki = 16'($urandom_range(1, 2000));
            2: ki = 16'($urandom_range(0, 65535));
            default: ki = 16'hffff;
         endcase
         case ($urandom_range(0, 3))
            0: pper = 0;
            1: pper = 255;
            default: pper = 16'($urandom_range(0, 255));
         endcase
         pmode = 16'($urandom_range(0, 1));
         hmode = 16'($urandom_range(0, 1));
      end
      drain();
      csr_write(piaw_pkg::CSR_SETPOINT_CH0, {4'h0, sp0});
      csr_write(piaw_pkg::CSR_SETPOINT_CH1, {4'h0, sp1});
      csr_write(piaw_pkg::CSR_SETPOINT_HUM, sph);
      csr_write(piaw_pkg::CSR_GAIN_P, kp);
      csr_write(piaw_pkg::CSR_GAIN_I, ki);
      csr_write(piaw_pkg::CSR_PULSE_MODE, pmode);
      csr_write(piaw_pkg::CSR_PULSE_PERIOD, pper);
      csr_write(piaw_pkg::CSR_HUMIDITY_SENS, hmode);
      csr_valid <= 1'b0;
   endtask

   task automatic random_word();
      int         temp, hum, adc, sp;
      result_type r;
      if ($urandom_range(0, 7) == 0) cur_ch = ~cur_ch;
      sp = cur_ch ? int'(cfg_sp1) : int'(cfg_sp0);
      case ($urandom_range(0, 19))
         0: temp = $urandom_range(850, 2047);
         1, 2, 3: temp = int'($urandom_range(0, 4095)) - 2048;
         default: temp = clamp(sp + int'($urandom_range(0, 80)) - 40, -2048, 849);
      endcase
      if ($urandom_range(0, 3) == 0) hum = $urandom_range(0, 1000);
      else hum = clamp(int'(cfg_sph) + int'($urandom_range(0, 80)) - 40, 0, 1000);
      adc = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 79) : $urandom_range(80, 1023);
      send_word(cur_ch, temp[11:0], hum[9:0], adc[9:0], r);
      pending_results.push_back(r);
   endtask

   initial begin
      result_type r;
      // after reset every register is zero
      stim_table.push_back(item_row(0, 0, 0, 0, 1, 0, 0, 0));
      stim_table.push_back(item_row(0, -2048, 0, 0, 1, 0, 2048, 0));
      stim_table.push_back(item_row(0, 849, 0, 0, 1, 0, -849, 0));
      stim_table.push_back(item_row(0, 850, 0, 0, 1, 0, 0, 1));
      stim_table.push_back(item_row(1, 2047, 0, 0, 1, 0, 0, 1));
      stim_table.push_back(item_row(1, -1, 1000, 0, 1, 0, 1, 0));
      // full gains, humidity mode, pulse mode with zero period
      stim_table.push_back(csr_row(piaw_pkg::CSR_SETPOINT_CH0, 16'h07ff));
      stim_table.push_back(csr_row(piaw_pkg::CSR_SETPOINT_CH1, 16'h0800));
      stim_table.push_back(csr_row(piaw_pkg::CSR_SETPOINT_HUM, 16'd1000));
      stim_table.push_back(csr_row(piaw_pkg::CSR_GAIN_P, 16'hffff));
      stim_table.push_back(csr_row(piaw_pkg::CSR_GAIN_I, 16'hffff));
      stim_table.push_back(csr_row(piaw_pkg::CSR_HUMIDITY_SENS, 16'd1));
      stim_table.push_back(csr_row(piaw_pkg::CSR_PULSE_MODE, 16'd1));
      stim_table.push_back(csr_row(piaw_pkg::CSR_PULSE_PERIOD, 16'd0));
      stim_table.push_back(item_row(0, -2048, 0, 0, 1, 32767, 4095, 0));
      stim_table.push_back(item_row(0, 2047, 0, 0, 1, 0, 0, 1));
      stim_table.push_back(item_row(1, 0, 500, 79, 1, 0, 0, 1));
      stim_table.push_back(item_row(1, 0, 0, 80, 1, 32767, 1000, 0));
      stim_table.push_back(item_row(1, 0, 1000, 1023, 1, 0, 0, 0));
      stim_table.push_back(item_row(0, 849, 0, 0));
      // negative error clears at the limit, drive floors at zero
      stim_table.push_back(csr_row(piaw_pkg::CSR_SETPOINT_CH0, 16'h0800));
      stim_table.push_back(csr_row(piaw_pkg::CSR_GAIN_P, 16'd1));
      stim_table.push_back(csr_row(piaw_pkg::CSR_GAIN_I, 16'd3));
      stim_table.push_back(csr_row(piaw_pkg::CSR_PULSE_MODE, 16'd0));
      stim_table.push_back(csr_row(piaw_pkg::CSR_PULSE_PERIOD, 16'd255));
      stim_table.push_back(csr_row(piaw_pkg::CSR_HUMIDITY_SENS, 16'd0));
      stim_table.push_back(item_row(0, 849, 0, 0, 1, 0, -2897, 0));
      stim_table.push_back(item_row(1, -2048, 0, 0, 1, 0, 0, 0));
      // pure integral action builds up
      stim_table.push_back(csr_row(piaw_pkg::CSR_GAIN_P, 16'd0));
      stim_table.push_back(csr_row(piaw_pkg::CSR_GAIN_I, 16'hffff));
      stim_table.push_back(csr_row(piaw_pkg::CSR_SETPOINT_CH0, 16'h07ff));
      stim_table.push_back(item_row(0, -2048, 0, 0));
      stim_table.push_back(item_row(0, -2048, 0, 0));
      stim_table.push_back(item_row(0, 2046, 0, 0));
      stim_table.push_back(item_row(0, 1000, 0, 0));
      // widest pulse limit on channel 1
      stim_table.push_back(csr_row(piaw_pkg::CSR_PULSE_MODE, 16'd1));
      stim_table.push_back(csr_row(piaw_pkg::CSR_GAIN_P, 16'd1));
      stim_table.push_back(csr_row(piaw_pkg::CSR_SETPOINT_CH1, 16'h07ff));
      stim_table.push_back(item_row(1, -2048, 0, 0));
      stim_table.push_back(item_row(1, 849, 0, 0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         if (stim_table[i].is_csr) begin
            if (i == 0 || !stim_table[i-1].is_csr) drain();
            csr_write(stim_table[i].idx, stim_table[i].wdata);
            if (i == stim_table.size() - 1 || !stim_table[i+1].is_csr) csr_valid <= 1'b0;
         end else begin
            send_word(stim_table[i].ch, stim_table[i].temp, stim_table[i].hum,
                      stim_table[i].adc, r);
            pending_results.push_back(stim_table[i].typed ? stim_table[i].res : r);
         end
      end

      // channel 0 integrator builds up with words back to back
      drain();
      csr_write(piaw_pkg::CSR_GAIN_P, 16'd0);
      csr_write(piaw_pkg::CSR_GAIN_I, 16'hffff);
      csr_write(piaw_pkg::CSR_SETPOINT_CH0, 16'h07ff);
      csr_valid <= 1'b0;
      idle_pct = 0;
      repeat (SOAK_WORDS) begin
         send_word(0, -2048, 0, 0, r);
         pending_results.push_back(r);
      end
      send_word(0, 2047, 0, 0, r);
      pending_results.push_back(r);

      for (int p = 0; p < PHASES; p++) begin
         program_phase(p);
         idle_pct = (p % 3 == 2) ? 0 : 35;
         repeat (PHASE_WORDS) random_word();
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0) $display("PASS pi_controller_antiwindup");
      else $display("FAIL pi_controller_antiwindup");
      $finish;
   end

endmodule
